@@ rtl/core/rwt_pkg.sv @@
package rwt_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int MAC_W = 48;
  localparam int CNT_W = 24;
  localparam int STAMP_W = 32;

  localparam logic REQ_CHECK = 1'b0;
  localparam logic REQ_RECORD = 1'b1;

  typedef struct packed {
    logic               live;
    logic [MAC_W-1:0]   addr;
    logic [CNT_W-1:0]   count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [MAC_W-1:0]   addr;
    logic [CNT_W-1:0]   count;
    logic [STAMP_W-1:0] stamp;
  } wr_t;

endpackage

@@ rtl/core/rwt_table.sv @@
module rwt_table (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [rwt_pkg::IDX_W-1:0] rd_idx,
  output rwt_pkg::entry_t       rd_entry,
  input  rwt_pkg::wr_t          wr
);

  logic [rwt_pkg::ENTRIES-1:0]     live;
  logic [rwt_pkg::MAC_W-1:0]       addr  [rwt_pkg::ENTRIES];
  logic [rwt_pkg::CNT_W-1:0]       count [rwt_pkg::ENTRIES];
  logic [rwt_pkg::STAMP_W-1:0]     stamp [rwt_pkg::ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (wr.en) begin
      live[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      addr[wr.idx]  <= wr.addr;
      count[wr.idx] <= wr.count;
      stamp[wr.idx] <= wr.stamp;
    end
  end

  always_comb begin
    rd_entry.live  = live[rd_idx];
    rd_entry.addr  = addr[rd_idx];
    rd_entry.count = count[rd_idx];
    rd_entry.stamp = stamp[rd_idx];
  end

endmodule

@@ rtl/core/rwt_seq.sv @@
module rwt_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type,
  input  logic [rwt_pkg::MAC_W-1:0]   sender_mac,
  input  logic [rwt_pkg::CNT_W-1:0]   frame_counter,
  output logic                        valid,
  output logic                        is_fresh,
  output logic [rwt_pkg::IDX_W-1:0]   rd_idx,
  input  rwt_pkg::entry_t             rd_entry,
  output rwt_pkg::wr_t                wr
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [rwt_pkg::IDX_W-1:0] LAST_IDX = rwt_pkg::IDX_W'(rwt_pkg::ENTRIES - 1);

  logic [1:0]                    state;
  logic [rwt_pkg::IDX_W-1:0]     idx;
  logic                          req;
  logic [rwt_pkg::MAC_W-1:0]     mac;
  logic [rwt_pkg::CNT_W-1:0]     cnt;
  logic                          found;
  logic [rwt_pkg::IDX_W-1:0]     found_idx;
  logic [rwt_pkg::CNT_W-1:0]     found_count;
  logic                          empty_seen;
  logic [rwt_pkg::IDX_W-1:0]     empty_idx;
  logic [rwt_pkg::IDX_W-1:0]     lru_idx;
  logic [rwt_pkg::STAMP_W-1:0]   lru_stamp;
  logic [rwt_pkg::STAMP_W-1:0]   use_stamp;
  logic [rwt_pkg::STAMP_W-1:0]   use_stamp_next;

  logic hit;
  logic newer;

  assign busy   = (state != ST_IDLE);
  assign rd_idx = idx;
  assign hit    = rd_entry.live && (rd_entry.addr == mac);
  assign newer  = cnt > found_count;
  assign use_stamp_next = use_stamp + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= 1'b0;
      use_stamp <= '0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (idx == LAST_IDX) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          state <= ST_IDLE;
          if (req == rwt_pkg::REQ_CHECK) begin
            valid <= 1'b1;
          end else begin
            use_stamp <= use_stamp_next;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // one entry per cycle through the shared compare unit
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      idx        <= '0;
      found      <= 1'b0;
      empty_seen <= 1'b0;
      if (start) begin
        req <= req_type;
        mac <= sender_mac;
        cnt <= frame_counter;
      end
    end else if (state == ST_SCAN) begin
      idx <= idx + 1'b1;
      if (hit && !found) begin
        found       <= 1'b1;
        found_idx   <= idx;
        found_count <= rd_entry.count;
      end
      if (!rd_entry.live && !empty_seen) begin
        empty_seen <= 1'b1;
        empty_idx  <= idx;
      end
      if (idx == '0) begin
        lru_idx   <= idx;
        lru_stamp <= rd_entry.stamp;
      end else if (rd_entry.stamp < lru_stamp) begin
        lru_idx   <= idx;
        lru_stamp <= rd_entry.stamp;
      end
    end
    if (state == ST_DONE && req == rwt_pkg::REQ_CHECK) begin
      is_fresh <= !found || newer;
    end
  end

  always_comb begin
    wr.en    = (state == ST_DONE) && (req == rwt_pkg::REQ_RECORD);
    wr.addr  = mac;
    wr.stamp = use_stamp_next;
    priority if (found) begin
      wr.idx   = found_idx;
      wr.count = newer ? cnt : found_count;
    end else if (empty_seen) begin
      wr.idx   = empty_idx;
      wr.count = cnt;
    end else begin
      wr.idx   = lru_idx;
      wr.count = cnt;
    end
  end

endmodule

@@ rtl/core/replay_window_table_top.sv @@
// channel   | handshake          | payload
// request   | start, busy        | req_type, sender_mac, frame_counter
// result    | valid (one cycle)  | is_fresh
//
// a request, once accepted, passes through the scan state and then the done state:
// one table entry is read and compared per cycle while scanning, then done decides and writes
// check requests give one result beat on valid in the same cycle in which busy falls
// record requests give no beat; they update the table and the use stamp
// synchronous reset empties the table and clears the stamp; no clearing pass
// the receiver cannot stall, so valid is never held
module replay_window_table_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type,
  input  logic [rwt_pkg::MAC_W-1:0]   sender_mac,
  input  logic [rwt_pkg::CNT_W-1:0]   frame_counter,
  output logic                        valid,
  output logic                        is_fresh
);

  logic [rwt_pkg::IDX_W-1:0] rd_idx;
  rwt_pkg::entry_t           rd_entry;
  rwt_pkg::wr_t              wr;

  rwt_table u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry),
    .wr       (wr)
  );

  rwt_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .sender_mac    (sender_mac),
    .frame_counter (frame_counter),
    .valid         (valid),
    .is_fresh      (is_fresh),
    .rd_idx        (rd_idx),
    .rd_entry      (rd_entry),
    .wr            (wr)
  );

endmodule

@@ tb/tb_replay_window_table_top.sv @@
module tb_replay_window_table_top;

  localparam int ITEMS      = 1600;
  localparam int POOL_SIZE  = 12;
  localparam int STALL_MAX  = 1000;
  localparam int REPORT_MAX = 10;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         req_type = rwt_pkg::REQ_CHECK;
  logic [rwt_pkg::MAC_W-1:0]    sender_mac = '0;
  logic [rwt_pkg::CNT_W-1:0]    frame_counter = '0;
  logic                         valid;
  logic                         is_fresh;

  replay_window_table_top uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .sender_mac(sender_mac),
    .frame_counter(frame_counter),
    .valid(valid),
    .is_fresh(is_fresh)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow copy of the table
  logic [rwt_pkg::MAC_W-1:0]   shadow_addr[rwt_pkg::ENTRIES];
  logic [rwt_pkg::CNT_W-1:0]   shadow_count[rwt_pkg::ENTRIES];
  bit                          shadow_live[rwt_pkg::ENTRIES];
  logic [rwt_pkg::STAMP_W-1:0] shadow_stamp[rwt_pkg::ENTRIES];
  logic [rwt_pkg::STAMP_W-1:0] shadow_use_stamp;

  logic expected_fresh_q[$];
  int   err_count = 0;
  int   stall_cycles = 0;

  initial begin
    for (int i = 0; i < rwt_pkg::ENTRIES; i++) begin
      shadow_addr[i] = '0;
      shadow_count[i] = '0;
      shadow_live[i] = 1'b0;
      shadow_stamp[i] = '0;
    end
    shadow_use_stamp = '0;
  end

  function automatic int lookup_sender(logic [rwt_pkg::MAC_W-1:0] mac);
    for (int i = 0; i < rwt_pkg::ENTRIES; i++)
      if (shadow_live[i] && shadow_addr[i] == mac) return i;
    return -1;
  endfunction

  function automatic int choose_victim();
    int v;
    v = 0;
    for (int i = 0; i < rwt_pkg::ENTRIES; i++) begin
      if (!shadow_live[i]) return i;
      if (shadow_stamp[i] < shadow_stamp[v]) v = i;
    end
    return v;
  endfunction

  function automatic void track_request(logic rq, logic [rwt_pkg::MAC_W-1:0] mac,
                                        logic [rwt_pkg::CNT_W-1:0] cnt);
    int slot;
    slot = lookup_sender(mac);
    if (rq == rwt_pkg::REQ_CHECK) begin
      expected_fresh_q.push_back((slot < 0) ? 1'b1 : (cnt > shadow_count[slot]));
    end else begin
      shadow_use_stamp = shadow_use_stamp + 1;
      if (slot < 0) begin
        slot = choose_victim();
        shadow_addr[slot] = mac;
        shadow_live[slot] = 1'b1;
        shadow_count[slot] = cnt;
      end else if (cnt > shadow_count[slot]) begin
        shadow_count[slot] = cnt;
      end
      shadow_stamp[slot] = shadow_use_stamp;
    end
  endfunction

  function automatic void log_mismatch(string what, logic exp_v, logic act_v);
    if (err_count < REPORT_MAX)
      $display("mismatch at %0t: %s expected %b actual %b", $realtime, what, exp_v, act_v);
    err_count++;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (valid) begin
        if (expected_fresh_q.size() == 0)
          log_mismatch("beat with nothing pending, is_fresh", 1'bx, is_fresh);
        else if (is_fresh !== expected_fresh_q[0])
          log_mismatch("is_fresh", expected_fresh_q[0], is_fresh);
        if (expected_fresh_q.size() != 0) void'(expected_fresh_q.pop_front());
      end
      if (start && !busy) track_request(req_type, sender_mac, frame_counter);
      if (valid || (start && !busy)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_MAX) begin
          $display("watchdog: no progress for %0d cycles", STALL_MAX);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  task automatic send_request(input logic rq, input logic [rwt_pkg::MAC_W-1:0] mac,
                              input logic [rwt_pkg::CNT_W-1:0] cnt, input bit may_idle);
    int gap;
    @(negedge clk);
    if (may_idle && $urandom_range(99) < 38) begin
      gap = $urandom_range(1, 12);
      start <= 1'b0;
      req_type <= 1'($urandom_range(1));
      sender_mac <= rwt_pkg::MAC_W'({$urandom, $urandom});
      frame_counter <= rwt_pkg::CNT_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    req_type <= rq;
    sender_mac <= mac;
    frame_counter <= cnt;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_fresh_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_table();
    send_request(rwt_pkg::REQ_CHECK, '0, '0, 1'b0);
    send_request(rwt_pkg::REQ_CHECK, '1, '1, 1'b1);
  endtask

  task automatic test_record_and_check();
    logic [rwt_pkg::MAC_W-1:0] mac_a;
    mac_a = 48'hA5A5_0F0F_3C3C;
    send_request(rwt_pkg::REQ_RECORD, mac_a, 24'd100, 1'b1);
    send_request(rwt_pkg::REQ_CHECK, mac_a, 24'd100, 1'b1);
    send_request(rwt_pkg::REQ_CHECK, mac_a, 24'd99, 1'b1);
    send_request(rwt_pkg::REQ_CHECK, mac_a, 24'd101, 1'b1);
    // lower counter must not pull the stored one down
    send_request(rwt_pkg::REQ_RECORD, mac_a, 24'd50, 1'b1);
    send_request(rwt_pkg::REQ_CHECK, mac_a, 24'd100, 1'b1);
    // address zero with counter zero must not match empty entries
    send_request(rwt_pkg::REQ_RECORD, '0, '0, 1'b1);
    send_request(rwt_pkg::REQ_CHECK, '0, '0, 1'b1);
    send_request(rwt_pkg::REQ_CHECK, '0, 24'd1, 1'b1);
    send_request(rwt_pkg::REQ_RECORD, '1, '1, 1'b1);
    send_request(rwt_pkg::REQ_CHECK, '1, '1, 1'b1);
  endtask

  task automatic test_fill_and_evict();
    for (int i = 0; i < 5; i++)
      send_request(rwt_pkg::REQ_RECORD, 48'h5A00_0000_0000 | rwt_pkg::MAC_W'(i),
                   rwt_pkg::CNT_W'(7 + i), 1'b1);
    send_request(rwt_pkg::REQ_RECORD, 48'hA5A5_0F0F_3C3C, 24'd100, 1'b1);
    // table full: the oldest entry (address zero) goes
    send_request(rwt_pkg::REQ_RECORD, 48'h0123_4567_89AB, 24'd3, 1'b1);
    send_request(rwt_pkg::REQ_CHECK, '0, '0, 1'b1);
    send_request(rwt_pkg::REQ_CHECK, 48'hA5A5_0F0F_3C3C, 24'd100, 1'b1);
    drain();
  endtask

  task automatic test_random_traffic();
    logic [rwt_pkg::MAC_W-1:0] pool[POOL_SIZE];
    logic [rwt_pkg::CNT_W-1:0] hint[POOL_SIZE];
    logic [rwt_pkg::MAC_W-1:0] mac;
    logic [rwt_pkg::CNT_W-1:0] cnt;
    logic                      rq;
    int                        idx;
    bit                        may_idle;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool[i] = rwt_pkg::MAC_W'({$urandom, $urandom});
      hint[i] = rwt_pkg::CNT_W'($urandom_range(2000));
    end
    for (int n = 0; n < ITEMS; n++) begin
      rq = 1'($urandom_range(1));
      if ($urandom_range(99) < 75) begin
        idx = $urandom_range(POOL_SIZE - 1);
        mac = pool[idx];
        case ($urandom_range(3))
          0: cnt = rwt_pkg::CNT_W'($urandom);
          1: cnt = hint[idx];
          2: cnt = hint[idx] + rwt_pkg::CNT_W'($urandom_range(1, 3));
          default: cnt = hint[idx] - rwt_pkg::CNT_W'($urandom_range(1, 3));
        endcase
        if (rq == rwt_pkg::REQ_RECORD && cnt > hint[idx]) hint[idx] = cnt;
      end else begin
        mac = rwt_pkg::MAC_W'({$urandom, $urandom});
        cnt = rwt_pkg::CNT_W'($urandom);
      end
      may_idle = !(n >= 600 && n < 900);
      send_request(rq, mac, cnt, may_idle);
      if (n % 400 == 399) drain();
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_record_and_check();
    test_fill_and_evict();
    test_random_traffic();
    drain();
    repeat (rwt_pkg::ENTRIES + 6) @(posedge clk);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", err_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/rwt_pkg.sv
rtl/core/rwt_table.sv
rtl/core/rwt_seq.sv
rtl/core/replay_window_table_top.sv
tb/tb_replay_window_table_top.sv
